FILE: src/cts_pkg.sv
// Package: shared constants, codes and types of the cube-table state machine.
package cts_pkg;

   // Field widths of the request and response words
   localparam int KIND_W      = 1;
   localparam int TERM_IDX_W  = 5;
   localparam int CUBE_IDX_W  = 3;
   localparam int CUBE_BITS_W = 20;
   localparam int COND_W      = 16;
   localparam int STATE_W     = 4;
   localparam int FLAGS_W     = 15;

   // Default machine dimensions
   localparam int DEF_STATE_BITS     = 4;
   localparam int DEF_CONDITION_BITS = 16;
   localparam int DEF_OUTPUT_COUNT   = 15;
   localparam int DEF_CUBES_PER_TERM = 8;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
   localparam logic [KIND_W-1:0] KIND_STEP = 1'b1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage

FILE: src/cts_req_if.sv
// Interface: request channel carrying load and step words.
interface cts_req_if import cts_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [KIND_W-1:0]      kind;
   logic [TERM_IDX_W-1:0]  term_index;
   logic [CUBE_IDX_W-1:0]  cube_index;
   logic [CUBE_BITS_W-1:0] cube_care;
   logic [CUBE_BITS_W-1:0] cube_value;
   logic                   cube_valid;
   logic [COND_W-1:0]      condition_inputs;

   modport source (output valid, kind, term_index, cube_index, cube_care, cube_value,
                   cube_valid, condition_inputs, input ready);
   modport sink   (input valid, kind, term_index, cube_index, cube_care, cube_value,
                   cube_valid, condition_inputs, output ready);
endinterface

FILE: src/cts_rsp_if.sv
// Interface: response channel carrying one word per step.
interface cts_rsp_if import cts_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [STATE_W-1:0] present_state;
   logic [FLAGS_W-1:0] output_flags;
   logic [STATE_W-1:0] next_state;
   logic               next_seen;
   logic               ended_at_start;

   modport source (output valid, present_state, output_flags, next_state, next_seen,
                   ended_at_start, input ready);
   modport sink   (input valid, present_state, output_flags, next_state, next_seen,
                   ended_at_start, output ready);
endinterface

FILE: src/cube_table_sr_state_machine.sv
// Top level: PLA-style cube-table state machine with set/reset state bits.
//
// Usage:
//   req channel: a load word (kind = load) writes one cube (care, value, valid)
//   into slot cube_index of term term_index and gives no response. Out-of-range
//   term or slot loads are dropped. A step word (kind = step) evaluates all
//   terms on the row {condition inputs, state} and gives exactly one rsp word.
//   A step is evaluated through the single read port of the cube store,
//   which yields one cube per cycle to one shared match unit. A new step is
//   not accepted until the earlier one has finished; loads are taken one per
//   cycle while idle. req ready is low while a step is being evaluated.
//   rsp is an output register: a finished word waits there while the next
//   word is accepted; a step that finishes while rsp is still stalled holds
//   in its last state until the receiver takes the earlier word.
//   Reset: state goes to zero, the visited map and all cube valid bits clear
//   at once; the cube store itself is not cleared, no sweep is needed.
module cube_table_sr_state_machine import cts_pkg::*; #(
   parameter int STATE_BITS     = DEF_STATE_BITS,
   parameter int CONDITION_BITS = DEF_CONDITION_BITS,
   parameter int OUTPUT_COUNT   = DEF_OUTPUT_COUNT,
   parameter int CUBES_PER_TERM = DEF_CUBES_PER_TERM
) (
   input logic        clock,
   input logic        reset,
   cts_req_if.sink    req,
   cts_rsp_if.source  rsp
);

   localparam int TERM_COUNT  = 2 * STATE_BITS + OUTPUT_COUNT;
   localparam int CUBE_COUNT  = TERM_COUNT * CUBES_PER_TERM;
   localparam int ROW_BITS    = STATE_BITS + CONDITION_BITS;
   localparam int STATE_COUNT = 1 << STATE_BITS;
   localparam int TERM_W      = $clog2(TERM_COUNT);
   localparam int SLOT_W      = (CUBES_PER_TERM > 1) ? $clog2(CUBES_PER_TERM) : 1;
   localparam int CUBE_W      = $clog2(CUBE_COUNT);

   // Sequencer
   state_type state_ff, state_in;
   logic      req_ready;
   logic      scan_run;
   logic      finish_fire;

   // Scan counters and match pipeline
   logic [TERM_W-1:0]     term_ff, term_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [CUBE_W-1:0]     addr_ff, addr_in;
   logic                  scan_last;
   logic [TERM_W-1:0]     term_d_ff;
   logic                  cmp_ff, cmp_in;
   logic [2*ROW_BITS-1:0] rd_ff;
   logic                  rdv_ff;
   logic                  cube_hit;
   logic [TERM_COUNT-1:0] hits_ff, hits_in;

   // Cube store and its valid bits
   logic [2*ROW_BITS-1:0] cube_mem [CUBE_COUNT];
   logic                  valid_ff [CUBE_COUNT];
   logic                  load_fire;
   logic                  load_ok;
   logic [CUBE_W-1:0]     load_addr;

   // Machine state
   logic [STATE_BITS-1:0] cur_ff, cur_in;
   logic                  visited_ff [STATE_COUNT];
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [STATE_BITS-1:0] nxt_state;
   logic                  seen;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATE_W-1:0]    rsp_present_ff, rsp_next_ff;
   logic [FLAGS_W-1:0]    rsp_flags_ff;
   logic                  rsp_seen_ff, rsp_start_ff;

   logic                  req_fire;
   logic                  step_fire;

   assign req_fire  = req.valid && req_ready;
   assign step_fire = req_fire && (req.kind == KIND_STEP);
   assign load_fire = req_fire && (req.kind == KIND_LOAD);
   assign scan_last = (term_ff == TERM_W'(TERM_COUNT - 1)) &&
                      (slot_ff == SLOT_W'(CUBES_PER_TERM - 1));

   // Next state of the sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (step_fire) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready   = 1'b0;
      scan_run    = 1'b0;
      finish_fire = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready   = 1'b1;
         ST_SCAN:   scan_run    = 1'b1;
         ST_DRAIN:  ;
         ST_FINISH: finish_fire = !rsp_valid_ff || rsp.ready;
         default:   ;
      endcase
   end

   assign req.ready = req_ready;

   // Advance the term and slot counters one cube a cycle
   always_comb begin
      term_in = term_ff;
      slot_in = slot_ff;
      addr_in = addr_ff;
      if (step_fire) begin
         term_in = '0;
         slot_in = '0;
         addr_in = '0;
      end else if (scan_run) begin
         addr_in = addr_ff + CUBE_W'(1);
         if (slot_ff == SLOT_W'(CUBES_PER_TERM - 1)) begin
            slot_in = '0;
            term_in = term_ff + TERM_W'(1);
         end else begin
            slot_in = slot_ff + SLOT_W'(1);
         end
      end
   end

   assign cmp_in = scan_run;

   // Match one cube against the row: every cared position must agree
   assign cube_hit = rdv_ff &&
      (((row_ff ^ rd_ff[2*ROW_BITS-1:ROW_BITS]) & rd_ff[ROW_BITS-1:0]) == '0);

   // Collect term hits; clear at the start of a step
   always_comb begin
      hits_in = hits_ff;
      if (step_fire) begin
         hits_in = '0;
      end else if (cmp_ff && cube_hit) begin
         hits_in[term_d_ff] = 1'b1;
      end
   end

   // Build the row: a1 (state msb) at row bit 0, conditions above the state
   always_comb begin
      row_in = row_ff;
      if (step_fire) begin
         for (int i = 0; i < STATE_BITS; i++) begin
            row_in[i] = cur_ff[STATE_BITS-1-i];
         end
         row_in[ROW_BITS-1:STATE_BITS] = CONDITION_BITS'(req.condition_inputs);
      end
   end

   // Apply set and reset terms; reset wins
   always_comb begin
      for (int i = 0; i < STATE_BITS; i++) begin
         nxt_state[STATE_BITS-1-i] = (cur_ff[STATE_BITS-1-i] || hits_ff[i]) &&
                                     !hits_ff[STATE_BITS+i];
      end
   end

   assign seen = (nxt_state == cur_ff) || visited_ff[nxt_state];

   always_comb begin
      cur_in = cur_ff;
      if (finish_fire) cur_in = seen ? '0 : nxt_state;
   end

   // Load address and range check
   assign load_ok   = (32'(req.term_index) < TERM_COUNT) &&
                      (32'(req.cube_index) < CUBES_PER_TERM);
   assign load_addr = CUBE_W'(req.term_index) * CUBE_W'(CUBES_PER_TERM) +
                      CUBE_W'(req.cube_index);

   // Write on load, read one cube per cycle during the scan
   always_ff @(posedge clock) begin
      if (load_fire && load_ok) begin
         cube_mem[load_addr] <= {ROW_BITS'(req.cube_value), ROW_BITS'(req.cube_care)};
      end
      if (scan_run) begin
         rd_ff <= cube_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CUBE_COUNT; i++) valid_ff[i] <= 1'b0;
      end else if (load_fire && load_ok) begin
         valid_ff[load_addr] <= req.cube_valid;
      end
   end

   // Mark visited states; drop the map when a run ends
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STATE_COUNT; i++) visited_ff[i] <= 1'b0;
      end else if (finish_fire) begin
         if (seen) begin
            for (int i = 0; i < STATE_COUNT; i++) visited_ff[i] <= 1'b0;
         end else begin
            visited_ff[cur_ff] <= 1'b1;
         end
      end
   end

   assign rsp_valid_in = finish_fire ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         cmp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         cmp_ff       <= cmp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      term_ff   <= term_in;
      slot_ff   <= slot_in;
      addr_ff   <= addr_in;
      hits_ff   <= hits_in;
      row_ff    <= row_in;
      term_d_ff <= term_ff;
      if (scan_run) rdv_ff <= valid_ff[addr_ff];
   end

   // Hold the response word until taken
   always_ff @(posedge clock) begin
      if (finish_fire) begin
         rsp_present_ff <= STATE_W'(cur_ff);
         rsp_flags_ff   <= FLAGS_W'(hits_ff[TERM_COUNT-1:2*STATE_BITS]);
         rsp_next_ff    <= STATE_W'(nxt_state);
         rsp_seen_ff    <= seen;
         rsp_start_ff   <= seen && (nxt_state == '0);
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.present_state  = rsp_present_ff;
   assign rsp.output_flags   = rsp_flags_ff;
   assign rsp.next_state     = rsp_next_ff;
   assign rsp.next_seen      = rsp_seen_ff;
   assign rsp.ended_at_start = rsp_start_ff;

   // A new response word only comes out of the finish state
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("response raised outside finish state");

   // A load word never produces a response
   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (load_fire && state_ff == ST_IDLE) |=> !finish_fire)
      else $error("load word led to a response");

   // After a run ends, the machine sits in state zero while the word is held
   a_run_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_seen_ff) |-> cur_ff == '0)
      else $error("state not restarted after run end");

   // The last cube is still in the compare stage when draining
   a_drain_cmp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> cmp_ff)
      else $error("drain without pending compare");

   // Hit vector starts empty on every scan
   a_hits_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && step_fire) |=> hits_ff == '0)
      else $error("hit vector not cleared at step start");

endmodule
